// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the image rotation block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IRIM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IRIM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/irim_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irim_pkg
// Types, codes and defaults for the nearest-neighbour image rotation block.
// ----------------------------------------------------------------------------
package irim_pkg;

  localparam int SRC_MAX_WIDTH_DEF  = 256;
  localparam int SRC_MAX_HEIGHT_DEF = 256;
  localparam int DST_MAX_DIM_DEF    = 512;
  localparam int FRAC_BITS_DEF      = 10;

  localparam int SRC_DIM_W = 9;
  localparam int DST_DIM_W = 10;
  localparam int COEF_W    = 12;
  localparam int OFFS_W    = 21;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 21;
  localparam int PIX_W     = 8;

  localparam logic [SRC_DIM_W-1:0] SRC_DIM_RST = SRC_DIM_W'(256);
  localparam logic [DST_DIM_W-1:0] DST_DIM_RST = DST_DIM_W'(256);
  localparam logic signed [COEF_W-1:0] COS_RST = COEF_W'(1024);
  localparam logic signed [COEF_W-1:0] SIN_RST = '0;
  localparam logic signed [OFFS_W-1:0] OFFS_RST = '0;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_COS        = 3'd4,
    CFG_SIN        = 3'd5,
    CFG_OFFSET_X   = 3'd6,
    CFG_OFFSET_Y   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_READ,
    ST_OUT
  } irim_state_t;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel_in;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             outside;
    logic             frame_end;
  } result_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } map_status_t;

endpackage

// ----- sv/image_rotate_inverse_map_fixed_unit.sv -----
`timescale 1ns / 1ps
// A load beat is taken while the sequencer is idle; the next beat may follow in the next cycle.
// An emit beat passes through the mapping stages, the registered frame memory read and the
// output register before its result is valid; a point outside skips the memory read.
// The next beat is taken in the cycle after the result is registered, later while it is held.
// Reset is synchronous: counters clear, the frame is marked not loaded and the configuration
// registers take their defaults; the frame memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// image_rotate_inverse_map_fixed_unit
// Nearest-neighbour image rotation by inverse mapping over a stored source frame.
// ----------------------------------------------------------------------------
module image_rotate_inverse_map_fixed_unit
  import irim_pkg::*;
#(
  parameter int SRC_MAX_WIDTH  = SRC_MAX_WIDTH_DEF,
  parameter int SRC_MAX_HEIGHT = SRC_MAX_HEIGHT_DEF,
  parameter int DST_MAX_DIM    = DST_MAX_DIM_DEF,
  parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int DEPTH  = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LCW    = $clog2(SRC_MAX_WIDTH);
  localparam int LRW    = $clog2(SRC_MAX_HEIGHT);
  localparam int HW     = $clog2(DST_MAX_DIM);
  localparam int SWW    = $clog2(SRC_MAX_WIDTH + 1);
  localparam int SHW    = $clog2(SRC_MAX_HEIGHT + 1);
  localparam int DWW    = $clog2(DST_MAX_DIM + 1);

  logic [SRC_DIM_W-1:0]     src_width, src_height;
  logic [DST_DIM_W-1:0]     dst_width, dst_height;
  logic signed [COEF_W-1:0] cos_q10, sin_q10;
  logic signed [OFFS_W-1:0] offset_x_q10, offset_y_q10;

  logic [SWW-1:0] sw;
  logic [SHW-1:0] sh;
  logic [DWW-1:0] dw, dh;

  logic [LCW-1:0] load_col;
  logic [LRW-1:0] load_row;
  logic [HW-1:0]  emit_col, emit_row;
  logic           frame_ready;

  logic item_acc, wr_en, emit_start;
  logic load_col_last, load_row_last, emit_col_last, emit_row_last;
  logic [ADDR_W-1:0] wr_addr, map_addr;
  logic [PIX_W-1:0]  rd_data;
  map_status_t       map_stat;

  irim_state_t state, state_next;
  logic        rd_en, out_load, out_free;
  logic        inside_q, fend_q;
  result_t     out_next;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= SRC_DIM_RST;
      src_height   <= SRC_DIM_RST;
      dst_width    <= DST_DIM_RST;
      dst_height   <= DST_DIM_RST;
      cos_q10      <= COS_RST;
      sin_q10      <= SIN_RST;
      offset_x_q10 <= OFFS_RST;
      offset_y_q10 <= OFFS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width    <= cfg_data[SRC_DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height   <= cfg_data[SRC_DIM_W-1:0];
        CFG_DST_WIDTH:  dst_width    <= cfg_data[DST_DIM_W-1:0];
        CFG_DST_HEIGHT: dst_height   <= cfg_data[DST_DIM_W-1:0];
        CFG_COS:        cos_q10      <= $signed(cfg_data[COEF_W-1:0]);
        CFG_SIN:        sin_q10      <= $signed(cfg_data[COEF_W-1:0]);
        CFG_OFFSET_X:   offset_x_q10 <= $signed(cfg_data[OFFS_W-1:0]);
        CFG_OFFSET_Y:   offset_y_q10 <= $signed(cfg_data[OFFS_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_width == '0) begin
      sw = SWW'(1);
    end else if (32'(src_width) > 32'(SRC_MAX_WIDTH)) begin
      sw = SWW'(SRC_MAX_WIDTH);
    end else begin
      sw = SWW'(src_width);
    end
    if (src_height == '0) begin
      sh = SHW'(1);
    end else if (32'(src_height) > 32'(SRC_MAX_HEIGHT)) begin
      sh = SHW'(SRC_MAX_HEIGHT);
    end else begin
      sh = SHW'(src_height);
    end
    if (dst_width == '0) begin
      dw = DWW'(1);
    end else if (32'(dst_width) > 32'(DST_MAX_DIM)) begin
      dw = DWW'(DST_MAX_DIM);
    end else begin
      dw = DWW'(dst_width);
    end
    if (dst_height == '0) begin
      dh = DWW'(1);
    end else if (32'(dst_height) > 32'(DST_MAX_DIM)) begin
      dh = DWW'(DST_MAX_DIM);
    end else begin
      dh = DWW'(dst_height);
    end
  end

  // Raster counters
  assign item_stall = (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign wr_en      = item_acc && (item.mode == MODE_LOAD);
  assign emit_start = item_acc && (item.mode == MODE_EMIT) && frame_ready;

  assign load_col_last = ((SWW+1)'(load_col) + (SWW+1)'(1)) >= (SWW+1)'(sw);
  assign load_row_last = ((SHW+1)'(load_row) + (SHW+1)'(1)) >= (SHW+1)'(sh);
  assign emit_col_last = ((DWW+1)'(emit_col) + (DWW+1)'(1)) >= (DWW+1)'(dw);
  assign emit_row_last = ((DWW+1)'(emit_row) + (DWW+1)'(1)) >= (DWW+1)'(dh);

  assign wr_addr = ADDR_W'(ADDR_W'(load_row) * ADDR_W'(SRC_MAX_WIDTH) + ADDR_W'(load_col));

  always_ff @(posedge clk) begin
    if (rst) begin
      load_col    <= '0;
      load_row    <= '0;
      emit_col    <= '0;
      emit_row    <= '0;
      frame_ready <= 1'b0;
    end else if (wr_en) begin
      if (load_col_last) begin
        load_col <= '0;
        if (load_row_last) begin
          load_row <= '0;
        end else begin
          load_row <= load_row + LRW'(1);
        end
      end else begin
        load_col <= load_col + LCW'(1);
      end
      if (load_col_last && load_row_last) begin
        frame_ready <= 1'b1;
      end else if (load_col == '0 && load_row == '0) begin
        frame_ready <= 1'b0;
      end
      if (load_col == '0 && load_row == '0) begin
        emit_col <= '0;
        emit_row <= '0;
      end
    end else if (emit_start) begin
      if (emit_col_last) begin
        emit_col <= '0;
        if (emit_row_last) begin
          emit_row <= '0;
        end else begin
          emit_row <= emit_row + HW'(1);
        end
      end else begin
        emit_col <= emit_col + HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_start) begin
      fend_q <= emit_col_last && emit_row_last;
    end
    if (map_stat.valid) begin
      inside_q <= map_stat.hit;
    end
  end

  irim_map #(
    .SRC_MAX_WIDTH  (SRC_MAX_WIDTH),
    .SRC_MAX_HEIGHT (SRC_MAX_HEIGHT),
    .DST_MAX_DIM    (DST_MAX_DIM),
    .FRAC_BITS      (FRAC_BITS)
  ) u_map (
    .clk   (clk),
    .rst   (rst),
    .start (emit_start),
    .h     (emit_col),
    .v     (emit_row),
    .cos_c (cos_q10),
    .sin_c (sin_q10),
    .off_x (offset_x_q10),
    .off_y (offset_y_q10),
    .sw    (sw),
    .sh    (sh),
    .stat  (map_stat),
    .addr  (map_addr)
  );

  irim_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (PIX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (item.pixel_in),
    .rd_en   (rd_en),
    .rd_addr (map_addr),
    .rd_data (rd_data)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    state_next         = state;
    rd_en              = 1'b0;
    out_load           = 1'b0;
    out_next.pixel_out = rd_data;
    out_next.outside   = 1'b0;
    out_next.frame_end = fend_q;
    case (state)
      ST_IDLE: begin
        if (emit_start) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        if (map_stat.valid) begin
          if (map_stat.hit) begin
            rd_en      = 1'b1;
            state_next = ST_READ;
          end else begin
            out_next.pixel_out = '0;
            out_next.outside   = 1'b1;
            if (out_free) begin
              out_load   = 1'b1;
              state_next = ST_IDLE;
            end else begin
              state_next = ST_OUT;
            end
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_next.pixel_out = inside_q ? rd_data : '0;
        out_next.outside   = !inside_q;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= out_next;
    end
  end

  `IRIM_ASSERT_IMP(a_map_only_when_waiting, map_stat.valid, state == ST_MAP, "Map out of turn")
  `IRIM_ASSERT_NXT(a_start_enters_map, emit_start, state == ST_MAP, "Emit beat not mapped")
  `IRIM_ASSERT_IMP(a_no_read_with_write, wr_en, !rd_en, "Frame memory read and write together")
  `IRIM_ASSERT_NXT(a_read_has_data, rd_en, state == ST_READ || state == ST_OUT, "Memory read lost")

endmodule

// ----- sv/irim_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irim_store
// Source frame memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module irim_store #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/irim_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irim_map
// Three-stage inverse mapping of a destination position to a source address.
// ----------------------------------------------------------------------------
module irim_map
  import irim_pkg::*;
#(
  parameter int SRC_MAX_WIDTH  = SRC_MAX_WIDTH_DEF,
  parameter int SRC_MAX_HEIGHT = SRC_MAX_HEIGHT_DEF,
  parameter int DST_MAX_DIM    = DST_MAX_DIM_DEF,
  parameter int FRAC_BITS      = FRAC_BITS_DEF,
  localparam int HW     = $clog2(DST_MAX_DIM),
  localparam int SWW    = $clog2(SRC_MAX_WIDTH + 1),
  localparam int SHW    = $clog2(SRC_MAX_HEIGHT + 1),
  localparam int ADDR_W = $clog2(SRC_MAX_WIDTH * SRC_MAX_HEIGHT)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [HW-1:0]            h,
  input  logic [HW-1:0]            v,
  input  logic signed [COEF_W-1:0] cos_c,
  input  logic signed [COEF_W-1:0] sin_c,
  input  logic signed [OFFS_W-1:0] off_x,
  input  logic signed [OFFS_W-1:0] off_y,
  input  logic [SWW-1:0]           sw,
  input  logic [SHW-1:0]           sh,
  output map_status_t              stat,
  output logic [ADDR_W-1:0]        addr
);

  localparam int PW    = COEF_W + HW + 1;
  localparam int SUM_W = ((PW > OFFS_W) ? PW : OFFS_W) + 2;
  localparam int XW    = SUM_W - FRAC_BITS;
  localparam int CW    = XW + SWW + SHW;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic                    va, vb, vc;
  logic signed [PW-1:0]    p_ch, p_sv, p_sh, p_cv;
  logic signed [SUM_W-1:0] sx, sy;
  logic signed [XW-1:0]    x, y;
  logic [CW-1:0]           xu, yu;
  logic                    inside_c;
  logic                    hit;
  logic [ADDR_W-1:0]       addr_c;
  logic signed [PW-1:0]    hs, vs;

  assign hs = PW'($signed({1'b0, h}));
  assign vs = PW'($signed({1'b0, v}));

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= start;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    p_ch <= PW'(cos_c) * hs;
    p_sv <= PW'(sin_c) * vs;
    p_sh <= PW'(sin_c) * hs;
    p_cv <= PW'(cos_c) * vs;
  end

  always_ff @(posedge clk) begin
    sx <= SUM_W'(p_ch) + SUM_W'(p_sv) + SUM_W'(off_x) + HALF;
    sy <= SUM_W'(p_cv) - SUM_W'(p_sh) + SUM_W'(off_y) + HALF;
  end

  always_comb begin
    x  = XW'(sx >>> FRAC_BITS);
    y  = XW'(sy >>> FRAC_BITS);
    xu = CW'(x[XW-2:0]);
    yu = CW'(y[XW-2:0]);
    inside_c = !x[XW-1] && !y[XW-1] && (xu < CW'(sw)) && (yu < CW'(sh));
    addr_c = ADDR_W'(ADDR_W'(yu) * ADDR_W'(SRC_MAX_WIDTH) + ADDR_W'(xu));
  end

  always_ff @(posedge clk) begin
    hit  <= inside_c;
    addr <= addr_c;
  end

  assign stat.valid = vc;
  assign stat.hit   = hit;

endmodule
